// ===== design/edmf_pkg.sv =====
`timescale 1ns / 1ps

package edmf_pkg;

    localparam int WINDOW_SIZE = 5;

    localparam int ECHO_W    = 16;
    localparam int DIST_W    = 15;
    localparam int SAMPLES_W = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 15;

    localparam int SCALE_W     = 9;
    localparam int SCALE_SHIFT = 10;
    localparam logic [SCALE_W-1:0] SCALE_NUM = 9'd281;
    localparam int PROD_W = ECHO_W + SCALE_W;

    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
    localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AVOID     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EMERGENCY = 2'd2;

    localparam logic [DIST_W-1:0] MIN_VALID_RESET = 15'd32;
    localparam logic [DIST_W-1:0] AVOID_RESET     = 15'd480;
    localparam logic [DIST_W-1:0] EMERGENCY_RESET = 15'd240;

    typedef struct packed {
        logic              reject;
        logic [DIST_W-1:0] distance;
    } edmf_item_t;

    typedef struct packed {
        logic [DIST_W-1:0] avoid;
        logic [DIST_W-1:0] emergency;
    } edmf_thresh_t;

endpackage

// ===== design/edmf_front.sv =====
`timescale 1ns / 1ps

module edmf_front
    import edmf_pkg::*;
(
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [ECHO_W-1:0] s_echo_width_us,
    input  logic [DIST_W-1:0] min_valid_distance,
    output logic              push_valid,
    output edmf_item_t        push_item,
    input  logic              push_ready
);

    logic [PROD_W-1:0] product;
    logic [DIST_W-1:0] distance;

    // width * 281 / 1024, max 17983
    assign product  = PROD_W'(s_echo_width_us) * PROD_W'(SCALE_NUM);
    assign distance = product[SCALE_SHIFT +: DIST_W];

    assign push_item.distance = distance;
    assign push_item.reject   = (s_echo_width_us == '0) || (distance < min_valid_distance);
    assign push_valid         = s_valid;
    assign s_ready            = push_ready;

endmodule

// ===== design/edmf_queue.sv =====
`timescale 1ns / 1ps

module edmf_queue
    import edmf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_valid,
    output logic       push_ready,
    input  edmf_item_t push_item,
    output logic       pop_valid,
    input  logic       pop_ready,
    output edmf_item_t pop_item
);

    edmf_item_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  fill_reg;
    logic [QCNT_W-1:0]  fill_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (fill_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        fill_next = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            fill_reg <= fill_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== design/edmf_back.sv =====
`timescale 1ns / 1ps

module edmf_back
    import edmf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  edmf_item_t           pop_item,
    input  edmf_thresh_t         thresh,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DIST_W-1:0]    m_median_distance,
    output logic                 m_distance_valid,
    output logic                 m_obstacle_close,
    output logic                 m_obstacle_emergency,
    output logic [SAMPLES_W-1:0] m_samples_held
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RANK = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [DIST_W-1:0]   window_reg [WINDOW_SIZE];
    logic [CNT_W-1:0]    count_reg;
    logic [IDX_W-1:0]    slot_reg;
    logic [IDX_W-1:0]    cand_reg;
    logic                valid_med_reg;
    logic [DIST_W-1:0]   lo_reg;
    logic [DIST_W-1:0]   hi_reg;

    logic                out_valid_reg;
    logic [DIST_W-1:0]   out_median_reg;
    logic                out_dvalid_reg;
    logic                out_close_reg;
    logic                out_emerg_reg;
    logic [SAMPLES_W-1:0] out_samples_reg;

    logic [DIST_W-1:0]   cand_val;
    logic [CNT_W-1:0]    rank;
    logic [CNT_W-1:0]    k_lo;
    logic [CNT_W-1:0]    k_hi;
    logic                last_cand;
    logic [DIST_W:0]     pair_sum;
    logic [DIST_W-1:0]   median;
    logic                out_free;
    logic                take;

    assign out_free  = !out_valid_reg || m_ready;
    assign pop_ready = (state_reg == ST_IDLE);
    assign take      = pop_valid && pop_ready;

    assign cand_val  = window_reg[cand_reg];
    assign k_lo      = (count_reg - CNT_W'(1)) >> 1;
    assign k_hi      = count_reg >> 1;
    assign last_cand = (CNT_W'(cand_reg) == count_reg - CNT_W'(1));
    assign pair_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign median    = valid_med_reg ? pair_sum[DIST_W:1] : '0;

    // stable rank: ties broken by slot position
    always_comb begin
        rank = '0;
        for (int j = 0; j < WINDOW_SIZE; j++) begin
            if (CNT_W'(j) < count_reg) begin
                if ((window_reg[j] < cand_val) ||
                    ((window_reg[j] == cand_val) && (IDX_W'(j) < cand_reg))) begin
                    rank = rank + CNT_W'(1);
                end
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    state_next = pop_item.reject ? ST_EMIT : ST_RANK;
                end
            end
            ST_RANK: begin
                if (last_cand) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            slot_reg      <= '0;
            cand_reg      <= '0;
            valid_med_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= ((state_reg == ST_EMIT) && out_free) ||
                             (out_valid_reg && !m_ready);
            case (state_reg)
                ST_IDLE: begin
                    if (take) begin
                        cand_reg <= '0;
                        if (pop_item.reject) begin
                            count_reg     <= '0;
                            slot_reg      <= '0;
                            valid_med_reg <= 1'b0;
                        end else begin
                            valid_med_reg <= 1'b1;
                            slot_reg <= (slot_reg == IDX_W'(WINDOW_SIZE - 1)) ?
                                        '0 : slot_reg + IDX_W'(1);
                            if (count_reg != CNT_W'(WINDOW_SIZE)) begin
                                count_reg <= count_reg + CNT_W'(1);
                            end
                        end
                    end
                end
                ST_RANK: begin
                    if (!last_cand) begin
                        cand_reg <= cand_reg + IDX_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (take && !pop_item.reject) begin
            window_reg[slot_reg] <= pop_item.distance;
        end
        if (state_reg == ST_RANK) begin
            if (rank == k_lo) begin
                lo_reg <= cand_val;
            end
            if (rank == k_hi) begin
                hi_reg <= cand_val;
            end
        end
        if ((state_reg == ST_EMIT) && out_free) begin
            out_median_reg  <= median;
            out_dvalid_reg  <= valid_med_reg;
            out_close_reg   <= valid_med_reg && (median != '0) && (median <= thresh.avoid);
            out_emerg_reg   <= valid_med_reg && (median != '0) &&
                               (median <= thresh.emergency);
            out_samples_reg <= SAMPLES_W'(count_reg);
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_median_distance    = out_median_reg;
    assign m_distance_valid     = out_dvalid_reg;
    assign m_obstacle_close     = out_close_reg;
    assign m_obstacle_emergency = out_emerg_reg;
    assign m_samples_held       = out_samples_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg <= CNT_W'(WINDOW_SIZE)) && (slot_reg < IDX_W'(WINDOW_SIZE)))
        else $error("window count or slot out of range");

    a_rank_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RANK) |-> (count_reg != '0) && (CNT_W'(cand_reg) < count_reg))
        else $error("ranking with empty window or candidate past count");

    a_reject_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && pop_item.reject) |=> (count_reg == '0) && (state_reg == ST_EMIT))
        else $error("rejected sample did not empty the window");

    a_invalid_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_dvalid_reg) |->
        (out_median_reg == '0) && (out_samples_reg == '0) && !out_close_reg && !out_emerg_reg)
        else $error("invalid result carries data");

    a_emit_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) && out_free |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("result not presented after emit");

endmodule

// ===== design/echo_distance_median_filter_top.sv =====
`timescale 1ns / 1ps

// Channel   Ports                                          Direction
// input     s_valid s_ready s_echo_width_us                in
// result    m_valid m_ready m_median_distance m_distance_valid
//           m_obstacle_close m_obstacle_emergency m_samples_held   out
// config    cfg_valid cfg_ready cfg_index cfg_data         in
//
// Front end converts and classifies in the accept cycle and writes a 2-deep queue.
// Back end takes a beat only when idle and ranks the n samples then held (1..WINDOW_SIZE),
// the rank loop testing one window entry per cycle; a rejected beat skips ranking.
// Synchronous active-low reset empties the window, queue and output register.
// A stalled result holds the back end; the queue keeps the input side open for 2 beats.

module echo_distance_median_filter_top
    import edmf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ECHO_W-1:0]     s_echo_width_us,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DIST_W-1:0]     m_median_distance,
    output logic                  m_distance_valid,
    output logic                  m_obstacle_close,
    output logic                  m_obstacle_emergency,
    output logic [SAMPLES_W-1:0]  m_samples_held,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [DIST_W-1:0] min_valid_reg;
    logic [DIST_W-1:0] avoid_reg;
    logic [DIST_W-1:0] emergency_reg;
    edmf_thresh_t      thresh;

    logic       push_valid;
    logic       push_ready;
    edmf_item_t push_item;
    logic       pop_valid;
    logic       pop_ready;
    edmf_item_t pop_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_valid_reg <= MIN_VALID_RESET;
            avoid_reg     <= AVOID_RESET;
            emergency_reg <= EMERGENCY_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_MIN_VALID: min_valid_reg <= cfg_data;
                REG_AVOID:     avoid_reg     <= cfg_data;
                REG_EMERGENCY: emergency_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign thresh.avoid     = avoid_reg;
    assign thresh.emergency = emergency_reg;

    edmf_front u_front (
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_echo_width_us    (s_echo_width_us),
        .min_valid_distance (min_valid_reg),
        .push_valid         (push_valid),
        .push_item          (push_item),
        .push_ready         (push_ready)
    );

    edmf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    edmf_back u_back (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .pop_valid            (pop_valid),
        .pop_ready            (pop_ready),
        .pop_item             (pop_item),
        .thresh               (thresh),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_median_distance    (m_median_distance),
        .m_distance_valid     (m_distance_valid),
        .m_obstacle_close     (m_obstacle_close),
        .m_obstacle_emergency (m_obstacle_emergency),
        .m_samples_held       (m_samples_held)
    );

endmodule
